// ===== hw/rtl/pse_pkg.sv =====
`timescale 1ns / 1ps

package pse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  localparam int LIT_W  = 24;
  localparam int FRAC_W = 24;
  localparam int Q_W    = LIT_W + FRAC_W;
  localparam int HALF_W = Q_W / 2;
  localparam int ACC_W  = Q_W + HALF_W + 3;
  localparam int MAG_W  = ACC_W - FRAC_W;
  localparam int DIV_STEPS = Q_W + FRAC_W;
  localparam int CNT_W  = $clog2(DIV_STEPS);
  localparam int TYPE_W = 3;
  localparam int STAT_W = 3;

  localparam int IN_TDATA_W  = ((LIT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((Q_W + SP_W + 7) / 8) * 8;

  localparam logic [Q_W-1:0] Q_MAX_U = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN_U = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [TYPE_W-1:0] {
    REQ_PUSH = 3'd0,
    REQ_ADD  = 3'd1,
    REQ_SUB  = 3'd2,
    REQ_MUL  = 3'd3,
    REQ_DIV  = 3'd4
  } req_type_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIV0  = 3'd3,
    ST_SAT   = 3'd4
  } status_e;

  typedef struct packed {
    logic done;
    logic sat;
    logic dz;
  } alu_stat_t;

endpackage

// ===== hw/rtl/postfix_stack_evaluator.sv =====
`timescale 1ns / 1ps

// Postfix evaluator over a 16-entry stack of signed Q24.24 values. Each input
// beat carries one token (literal in tdata, token kind in tuser, end of
// expression in tlast) and yields one output beat with the new top, depth and
// status; a tlast token empties the stack after its result. Tokens are taken
// one at a time. A literal, a refused token or an unknown kind goes from decode
// straight to the finish state; add and subtract, multiply (four 24x24 partial
// products through one multiplier) and divide wait on the arithmetic unit, whose
// restoring divider forms one of 72 quotient bits per cycle. The output register
// lets the next token enter while a result is still waiting on the master side.
module postfix_stack_evaluator import pse_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [23:0] literal_value
  input  logic [TYPE_W-1:0]      s_axis_tuser,  // [2:0] req_type
  input  logic                   s_axis_tlast,  // is_last
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [47:0] top_value, [52:48] stack_depth
  output logic [STAT_W-1:0]      m_axis_tuser,  // [2:0] status
  output logic                   m_axis_tlast   // expression_done
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_LOAD   = 5'b00100,
    S_ALU    = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [TYPE_W-1:0]  kind_q, kind_d;
  logic [LIT_W-1:0]   lit_q, lit_d;
  logic               last_q, last_d;
  logic [SP_W-1:0]    sp_q, sp_d;
  logic [Q_W-1:0]     top_q, top_d;
  logic [STAT_W-1:0]  status_q, status_d;

  logic               out_valid_q, out_valid_d;
  logic [Q_W-1:0]     out_top_q, out_top_d;
  logic [SP_W-1:0]    out_depth_q, out_depth_d;
  logic [STAT_W-1:0]  out_status_q, out_status_d;
  logic               out_last_q, out_last_d;

  logic               ram_we;
  logic [STACK_AW-1:0] ram_addr;
  logic [Q_W-1:0]     ram_wdata, ram_rdata;
  logic [SP_W-1:0]    sp_m2;

  logic               alu_start;
  logic [Q_W-1:0]     alu_res;
  alu_stat_t          alu_st;

  assign sp_m2 = sp_q - SP_W'(2);

  pse_ram #(
    .WIDTH (Q_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  pse_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(alu_start),
    .op_i   (kind_q),
    .a_i    (ram_rdata),
    .b_i    (top_q),
    .res_o  (alu_res),
    .stat_o (alu_st)
  );

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    lit_d        = lit_q;
    last_d       = last_q;
    sp_d         = sp_q;
    top_d        = top_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_top_d    = out_top_q;
    out_depth_d  = out_depth_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_addr     = sp_m2[STACK_AW-1:0];
    ram_wdata    = alu_res;
    alu_start    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d  = s_axis_tuser;
          lit_d   = s_axis_tdata[LIT_W-1:0];
          last_d  = s_axis_tlast;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        status_d = ST_OK;
        state_d  = S_FINISH;
        if (kind_q == REQ_PUSH) begin
          if (sp_q == SP_W'(STACK_DEPTH)) begin
            status_d = ST_OVER;
          end else begin
            ram_we    = 1'b1;
            ram_addr  = sp_q[STACK_AW-1:0];
            ram_wdata = {lit_q, {FRAC_W{1'b0}}};
            top_d     = {lit_q, {FRAC_W{1'b0}}};
            sp_d      = sp_q + 1'b1;
          end
        end else if (kind_q == REQ_ADD || kind_q == REQ_SUB ||
                     kind_q == REQ_MUL || kind_q == REQ_DIV) begin
          if (sp_q < SP_W'(2)) begin
            status_d = ST_UNDER;
          end else begin
            // fetch the left operand; the right one is the cached top
            state_d = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        alu_start = 1'b1;
        state_d   = S_ALU;
      end
      S_ALU: begin
        if (alu_st.done) begin
          ram_we   = 1'b1;
          top_d    = alu_res;
          sp_d     = sp_q - 1'b1;
          status_d = alu_st.dz ? ST_DIV0 : (alu_st.sat ? ST_SAT : ST_OK);
          state_d  = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_top_d    = (sp_q != '0) ? top_q : '0;
          out_depth_d  = sp_q;
          out_status_d = status_q;
          out_last_d   = last_q;
          if (last_q) begin
            sp_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    lit_q        <= lit_d;
    last_q       <= last_d;
    top_q        <= top_d;
    status_q     <= status_d;
    out_top_q    <= out_top_d;
    out_depth_q  <= out_depth_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_depth_q, out_top_q});
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after a token");

  a_alu_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_st.done |-> state_q == S_ALU)
    else $error("arithmetic result outside its wait state");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[Q_W +: SP_W] <= SP_W'(STACK_DEPTH))
    else $error("reported depth beyond the stack size");

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(sp_q) == SP_W'(STACK_DEPTH) && state_q != S_FINISH |-> sp_q <= SP_W'(STACK_DEPTH))
    else $error("stack pointer past the stack size");

endmodule

// ===== hw/rtl/pse_ram.sv =====
`timescale 1ns / 1ps

module pse_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ===== hw/rtl/pse_alu.sv =====
`timescale 1ns / 1ps

module pse_alu import pse_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [TYPE_W-1:0]     op_i,
  input  logic signed [Q_W-1:0] a_i,
  input  logic signed [Q_W-1:0] b_i,
  output logic [Q_W-1:0]        res_o,
  output alu_stat_t             stat_o
);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } alu_state_e;

  alu_state_e state_q, state_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic              sat_q, sat_d;
  logic              dz_q, dz_d;
  logic [Q_W-1:0]    res_q, res_d;
  logic              neg_q, neg_d;
  logic              is_mul_q, is_mul_d;
  logic              big_q, big_d;
  logic [Q_W-1:0]    ma_q, ma_d;
  logic [Q_W-1:0]    mb_q, mb_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [Q_W-1:0]    prod_q, prod_d;
  logic [Q_W-1:0]    rem_q, rem_d;
  logic [Q_W-1:0]    quo_q, quo_d;
  logic [Q_W-1:0]    num_q, num_d;

  logic [Q_W-1:0]    ma_c, mb_c;
  logic [Q_W:0]      sum_c;
  logic [HALF_W-1:0] mx_c, my_c;
  logic [ACC_W-1:0]  addend_c;
  logic [Q_W:0]      rem_sh_c;
  logic [Q_W+1:0]    diff_c;
  logic [MAG_W-1:0]  mag_c;

  assign ma_c = a_i[Q_W-1] ? Q_W'(-a_i) : Q_W'(a_i);
  assign mb_c = b_i[Q_W-1] ? Q_W'(-b_i) : Q_W'(b_i);

  // cnt 0..3 picks the partial product, low halves first
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    begin mx_c = ma_q[HALF_W-1:0];   my_c = mb_q[HALF_W-1:0];   end
      2'd1:    begin mx_c = ma_q[HALF_W-1:0];   my_c = mb_q[Q_W-1:HALF_W]; end
      2'd2:    begin mx_c = ma_q[Q_W-1:HALF_W]; my_c = mb_q[HALF_W-1:0];   end
      default: begin mx_c = ma_q[Q_W-1:HALF_W]; my_c = mb_q[Q_W-1:HALF_W]; end
    endcase
  end

  always_comb begin
    case (cnt_q[2:0])
      3'd1:    addend_c = ACC_W'(prod_q);
      3'd4:    addend_c = ACC_W'(prod_q) << Q_W;
      default: addend_c = ACC_W'(prod_q) << HALF_W;
    endcase
  end

  assign rem_sh_c = {rem_q, num_q[Q_W-1]};
  assign diff_c   = {1'b0, rem_sh_c} - {2'b00, mb_q};
  assign mag_c    = is_mul_q ? acc_q[ACC_W-1:FRAC_W] : MAG_W'(quo_q);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    sat_d    = sat_q;
    dz_d     = dz_q;
    res_d    = res_q;
    neg_d    = neg_q;
    is_mul_d = is_mul_q;
    big_d    = big_q;
    ma_d     = ma_q;
    mb_d     = mb_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    num_d    = num_q;
    sum_c    = '0;

    case (state_q)
      A_IDLE: begin
        if (start_i) begin
          sat_d    = 1'b0;
          dz_d     = 1'b0;
          neg_d    = a_i[Q_W-1] ^ b_i[Q_W-1];
          ma_d     = ma_c;
          mb_d     = mb_c;
          cnt_d    = '0;
          big_d    = 1'b0;
          acc_d    = '0;
          rem_d    = '0;
          quo_d    = '0;
          num_d    = ma_c;
          is_mul_d = (op_i == REQ_MUL);
          if (op_i == REQ_ADD || op_i == REQ_SUB) begin
            sum_c = (op_i == REQ_ADD) ? {a_i[Q_W-1], a_i} + {b_i[Q_W-1], b_i}
                                      : {a_i[Q_W-1], a_i} - {b_i[Q_W-1], b_i};
            if (sum_c[Q_W] != sum_c[Q_W-1]) begin
              sat_d = 1'b1;
              res_d = sum_c[Q_W] ? Q_MIN_U : Q_MAX_U;
            end else begin
              res_d = sum_c[Q_W-1:0];
            end
            done_d = 1'b1;
          end else if (op_i == REQ_MUL) begin
            state_d = A_MUL;
          end else if (b_i == '0) begin
            dz_d   = 1'b1;
            res_d  = a_i[Q_W-1] ? Q_MIN_U : Q_MAX_U;
            done_d = 1'b1;
          end else begin
            state_d = A_DIV;
          end
        end
      end
      A_MUL: begin
        prod_d = Q_W'(mx_c * my_c);
        if (cnt_q != '0) begin
          acc_d = acc_q + addend_c;
        end
        if (cnt_q == CNT_W'(4)) begin
          // high-by-high product alone already past the range
          big_d   = |prod_q[Q_W-1:FRAC_W-1];
          state_d = A_FIN;
        end
        cnt_d = cnt_q + 1'b1;
      end
      A_DIV: begin
        big_d = big_q | quo_q[Q_W-1];
        num_d = {num_q[Q_W-2:0], 1'b0};
        if (!diff_c[Q_W+1]) begin
          rem_d = diff_c[Q_W-1:0];
          quo_d = {quo_q[Q_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh_c[Q_W-1:0];
          quo_d = {quo_q[Q_W-2:0], 1'b0};
        end
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = A_FIN;
        end
        cnt_d = cnt_q + 1'b1;
      end
      A_FIN: begin
        if (neg_q) begin
          if (big_q || mag_c > MAG_W'(Q_MIN_U)) begin
            sat_d = 1'b1;
            res_d = Q_MIN_U;
          end else begin
            res_d = Q_W'(-mag_c[Q_W-1:0]);
          end
        end else begin
          if (big_q || mag_c > MAG_W'(Q_MAX_U)) begin
            sat_d = 1'b1;
            res_d = Q_MAX_U;
          end else begin
            res_d = mag_c[Q_W-1:0];
          end
        end
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q    <= sat_d;
    dz_q     <= dz_d;
    res_q    <= res_d;
    neg_q    <= neg_d;
    is_mul_q <= is_mul_d;
    big_q    <= big_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    num_q    <= num_d;
  end

  assign res_o       = res_q;
  assign stat_o.done = done_q;
  assign stat_o.sat  = sat_q;
  assign stat_o.dz   = dz_q;

endmodule

// ===== sim/tb_postfix_stack_evaluator.sv =====
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator import pse_pkg::*; ();

  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    logic [Q_W-1:0]    top;
    logic [SP_W-1:0]   depth;
    logic [STAT_W-1:0] status;
    logic              done;
  } rpn_result_t;

  // token kinds outside the defined set; the block must ignore them
  localparam logic [TYPE_W-1:0] KIND_RSVD_LO  = 3'd5;
  localparam logic [TYPE_W-1:0] KIND_RSVD_MID = 3'd6;
  localparam logic [TYPE_W-1:0] KIND_RSVD_HI  = 3'd7;

  localparam int RANDOM_TOKENS = 1500;

  // bottom to top; the upper entries feed the operator cases
  localparam logic [LIT_W-1:0] FILL_LITS [STACK_DEPTH] = '{
    24'h000007, 24'hFFFFFE, 24'h000003, 24'hFFF000,
    24'h000064, 24'hAAAAAA, 24'h555555, 24'hFFFFFB,
    24'h000000, 24'h7FFFFF, 24'h000001, 24'h7FFFFF,
    24'hFFFFFF, 24'h800000, 24'h000000, 24'h000000
  };

  // 0/0, min*max, -1+min, max-min, 1/max, max/tiny, 0*x, -5/0, then a last divide
  localparam req_type_e UNWIND_OPS [9] = '{
    REQ_DIV, REQ_MUL, REQ_ADD, REQ_SUB, REQ_DIV,
    REQ_DIV, REQ_MUL, REQ_DIV, REQ_DIV
  };

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [TYPE_W-1:0]      s_axis_tuser  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;

  postfix_stack_evaluator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // evaluator state as the block should hold it
  q_t          calc_stack [STACK_DEPTH];
  int          calc_depth = 0;
  rpn_result_t pending_results [$];

  int errors          = 0;
  int results_checked = 0;
  int tokens_applied  = 0;
  int expressions     = 0;
  int status_seen [5] = '{default: 0};
  int burst_left      = 0;
  int rx_seg_left     = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("tb_postfix_stack_evaluator NOT OK");
    $finish;
  end

  function automatic logic [Q_W-1:0] q_mag(input q_t x);
    return x[Q_W-1] ? -x : x;
  endfunction

  // sign a magnitude and clamp to Q24.24
  function automatic q_t q_fit(input logic neg, input logic [Q_W+FRAC_W-1:0] mag,
                               input logic big, output logic sat);
    sat = 1'b0;
    if (neg) begin
      if (big || mag > {{FRAC_W{1'b0}}, Q_MIN_U}) begin
        sat = 1'b1;
        return Q_MIN_U;
      end
      return -mag[Q_W-1:0];
    end
    if (big || mag > {{FRAC_W{1'b0}}, Q_MAX_U}) begin
      sat = 1'b1;
      return Q_MAX_U;
    end
    return mag[Q_W-1:0];
  endfunction

  function automatic q_t q_addsub(input q_t a, input q_t b, input logic minus,
                                  output logic sat);
    logic [Q_W:0] s;
    s = minus ? {a[Q_W-1], a} - {b[Q_W-1], b} : {a[Q_W-1], a} + {b[Q_W-1], b};
    sat = s[Q_W] ^ s[Q_W-1];
    if (!sat) return s[Q_W-1:0];
    return s[Q_W] ? Q_MIN_U : Q_MAX_U;
  endfunction

  function automatic q_t q_mul(input q_t a, input q_t b, output logic sat);
    logic [Q_W-1:0]   ma, mb, hi_prod;
    logic [2*Q_W-1:0] prod;
    ma = q_mag(a);
    mb = q_mag(b);
    hi_prod = ma[Q_W-1:FRAC_W] * mb[Q_W-1:FRAC_W];
    prod = ma * mb;
    // integer parts alone reaching 2^23 count as saturated, even at exactly -2^47
    return q_fit(a[Q_W-1] ^ b[Q_W-1], prod[2*Q_W-1:FRAC_W],
                 hi_prod[Q_W-1:LIT_W-1] != '0, sat);
  endfunction

  function automatic q_t q_div(input q_t a, input q_t b, output logic sat);
    logic [Q_W+FRAC_W-1:0] num, den, quo;
    num = {q_mag(a), {FRAC_W{1'b0}}};
    den = {{FRAC_W{1'b0}}, q_mag(b)};
    quo = num / den;
    return q_fit(a[Q_W-1] ^ b[Q_W-1], quo, quo[Q_W+FRAC_W-1:Q_W] != '0, sat);
  endfunction

  task automatic eval_token(input logic [TYPE_W-1:0] kind, input logic [LIT_W-1:0] lit,
                            input logic last);
    rpn_result_t want;
    q_t          lhs, rhs, res;
    logic        sat;
    status_e     st;
    st  = ST_OK;
    sat = 1'b0;
    res = '0;
    if (kind == REQ_PUSH) begin
      if (calc_depth >= STACK_DEPTH) begin
        st = ST_OVER;
      end else begin
        calc_stack[calc_depth] = {lit, {FRAC_W{1'b0}}};
        calc_depth++;
      end
    end else if (kind <= REQ_DIV) begin
      if (calc_depth < 2) begin
        st = ST_UNDER;
      end else begin
        rhs = calc_stack[calc_depth-1];
        lhs = calc_stack[calc_depth-2];
        case (kind)
          REQ_ADD: res = q_addsub(lhs, rhs, 1'b0, sat);
          REQ_SUB: res = q_addsub(lhs, rhs, 1'b1, sat);
          REQ_MUL: res = q_mul(lhs, rhs, sat);
          default: begin
            if (rhs == '0) begin
              res = lhs[Q_W-1] ? Q_MIN_U : Q_MAX_U;
              st  = ST_DIV0;
            end else begin
              res = q_div(lhs, rhs, sat);
            end
          end
        endcase
        if (st == ST_OK && sat) st = ST_SAT;
        calc_depth--;
        calc_stack[calc_depth-1] = res;
      end
    end
    if (kind <= REQ_DIV) tokens_applied++;
    want.top    = (calc_depth > 0) ? calc_stack[calc_depth-1] : '0;
    want.depth  = SP_W'(calc_depth);
    want.status = st;
    want.done   = last;
    pending_results.insert(pending_results.size(), want);
    status_seen[st]++;
    if (last) begin
      calc_depth = 0;
      expressions++;
    end
  endtask

  // one beat into the block; sender runs in bursts with idle gaps between
  task automatic send_token(input logic [TYPE_W-1:0] kind, input logic [LIT_W-1:0] lit,
                            input logic last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(lit);
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    eval_token(kind, lit, last);
  endtask

  function automatic logic [LIT_W-1:0] rand_literal();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return LIT_W'(int'($urandom_range(0, 40)) - 20);
      4, 5, 6:    return LIT_W'(int'($urandom_range(0, 8192)) - 4096);
      7, 8:       return LIT_W'($urandom);
      default: begin
        case ($urandom_range(0, 4))
          0:       return 24'h7FFFFF;
          1:       return 24'h800000;
          2:       return 24'h000000;
          3:       return 24'hFFFFFF;
          default: return 24'h000001;
        endcase
      end
    endcase
  endfunction

  task automatic test_fill_and_overflow();
    foreach (FILL_LITS[i]) send_token(REQ_PUSH, FILL_LITS[i], 1'b0);
    send_token(REQ_PUSH, 24'h123456, 1'b0);   // stack full, must be refused
  endtask

  task automatic test_operator_cases();
    foreach (UNWIND_OPS[i])
      send_token(UNWIND_OPS[i], LIT_W'($urandom), i == $size(UNWIND_OPS) - 1);
  endtask

  task automatic test_underflow_and_unknown();
    send_token(REQ_MUL, 24'h000000, 1'b0);    // empty stack
    send_token(REQ_PUSH, 24'h000009, 1'b0);
    send_token(KIND_RSVD_LO, 24'hFFFFFF, 1'b0);
    send_token(REQ_DIV, 24'h000000, 1'b0);    // one entry only
    send_token(KIND_RSVD_MID, 24'h5A5A5A, 1'b0);
    send_token(KIND_RSVD_HI, 24'hA5A5A5, 1'b1);
  endtask

  // well-formed postfix with random content; may start on leftovers of noise
  task automatic send_expression();
    int   n_push, cap, d, nd;
    logic is_push;
    n_push = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
    cap    = ($urandom_range(0, 7) == 0) ? STACK_DEPTH + 1 : $urandom_range(2, STACK_DEPTH);
    while (n_push > 0 || calc_depth > 1) begin
      d = calc_depth;
      is_push = n_push > 0 && (d < 2 || (d < cap && $urandom_range(0, 99) < 55));
      if (is_push) begin
        n_push--;
        nd = (d < STACK_DEPTH) ? d + 1 : d;
        send_token(REQ_PUSH, rand_literal(), n_push == 0 && nd == 1);
      end else begin
        send_token(TYPE_W'($urandom_range(REQ_ADD, REQ_DIV)), LIT_W'($urandom),
                   n_push == 0 && d == 2);
      end
    end
  endtask

  task automatic test_random_expressions();
    int start;
    start = tokens_applied;
    while (tokens_applied - start < RANDOM_TOKENS) begin
      if ($urandom_range(0, 99) < 85) begin
        send_expression();
      end else begin
        repeat ($urandom_range(1, 6))
          send_token(TYPE_W'($urandom_range(0, (1 << TYPE_W) - 1)), LIT_W'($urandom),
                     $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // result checker plus receiver stall pattern
  always @(posedge clk_i) begin
    rpn_result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.top    = m_axis_tdata[Q_W-1:0];
      got.depth  = m_axis_tdata[Q_W +: SP_W];
      got.status = m_axis_tuser;
      got.done   = m_axis_tlast;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: top %h depth %0d status %0d done %b",
                   got.top, got.depth, got.status, got.done);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: expected top %h depth %0d status %0d done %b,",
                     results_checked, want.top, want.depth, want.status, want.done,
                     " got top %h depth %0d status %0d done %b",
                     got.top, got.depth, got.status, got.done);
        end
      end
    end
    if (rx_seg_left != 0) begin
      rx_seg_left--;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      rx_seg_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
      rx_seg_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(0, 10);
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_overflow();
    test_operator_cases();
    test_underflow_and_unknown();
    test_random_expressions();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d tokens over %0d expressions, %0d results checked, %0d mismatches",
             tokens_applied, expressions, results_checked, errors);
    $display("status mix: ok %0d, underflow %0d, overflow %0d, div by zero %0d, sat %0d",
             status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
             status_seen[ST_DIV0], status_seen[ST_SAT]);
    if (errors == 0)
      $display("tb_postfix_stack_evaluator OK");
    else
      $display("tb_postfix_stack_evaluator NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pse_pkg.sv
hw/rtl/pse_ram.sv
hw/rtl/pse_alu.sv
hw/rtl/postfix_stack_evaluator.sv
sim/tb_postfix_stack_evaluator.sv
